>>> sv/selective_repeat_receiver_unit_defines.svh
`ifndef SELECTIVE_REPEAT_RECEIVER_UNIT_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, masked while rst_n is low
`define SRR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, masked while rst_n is low
`define SRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/srr_pkg.sv
`timescale 1ns / 1ps

package srr_pkg;

    // Sequence number space
    localparam int SEQ_W = 16;

    // Held-frame buffer
    localparam int BUFFER_DEPTH = 32;
    localparam int SLOT_W = $clog2(BUFFER_DEPTH);

    // Upper bound on words produced by one frame
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    // Expected frame number after reset
    localparam logic [SEQ_W-1:0] EXPECTED_INIT = SEQ_W'(1);

    // Map a sequence number onto its buffer slot
    function automatic logic [SLOT_W-1:0] slot_of(input logic [SEQ_W-1:0] seq);
        return SLOT_W'(seq % BUFFER_DEPTH);
    endfunction

endpackage

>>> sv/srr_frame_if.sv
`timescale 1ns / 1ps

interface srr_frame_if;
    logic                     valid;
    logic                     ready;
    logic [srr_pkg::SEQ_W-1:0] frame_number;

    modport source (output valid, output frame_number, input ready);
    modport sink   (input valid, input frame_number, output ready);
endinterface

>>> sv/srr_result_if.sv
`timescale 1ns / 1ps

interface srr_result_if;
    logic                     valid;
    logic                     ready;
    logic                     is_nak;
    logic [srr_pkg::SEQ_W-1:0] ack_number;
    logic                     last;

    modport source (output valid, output is_nak, output ack_number, output last, input ready);
    modport sink   (input valid, input is_nak, input ack_number, input last, output ready);
endinterface

>>> sv/selective_repeat_receiver_unit.sv
`timescale 1ns / 1ps

// Selective repeat ARQ receiver. Each word on frame carries the sequence number of
// one arriving data frame; each word on result is an ACK or a NAK, with last set on
// the final word caused by that frame. The held-frame bitmap lives in a one-port-
// write, one-port-read synchronous memory with a registered read. After reset the
// block clears that memory and takes no frame meanwhile. A frame behind the expected
// one is taken and gives no word, an early frame gives a NAK, an in-order frame gives
// its ACK and then one ACK for every held frame drained after it (up to 31 more), the
// drain being paced by the single read of the memory per cycle while result takes
// each word. A stall on result holds the drain. One finished word waits in the output
// register while the next frame is taken.
module selective_repeat_receiver_unit (
    input  logic          clk,
    input  logic          rst_n,
    srr_frame_if.sink     frame,
    srr_result_if.source  result
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAIN,
        ST_NAK
    } state_t;

    // Control and output registers
    state_t                        state_reg,      state_next;
    logic [srr_pkg::SEQ_W-1:0]     expected_reg,   expected_next;
    logic [srr_pkg::SEQ_W-1:0]     pend_reg,       pend_next;
    logic [srr_pkg::CNT_W-1:0]     cnt_reg,        cnt_next;
    logic [srr_pkg::SLOT_W-1:0]    clr_cnt_reg,    clr_cnt_next;
    logic                          out_valid_reg,  out_valid_next;
    logic                          out_nak_reg,    out_nak_next;
    logic [srr_pkg::SEQ_W-1:0]     out_num_reg,    out_num_next;
    logic                          out_last_reg,   out_last_next;

    // Held-frame memory
    logic                          held_mem [srr_pkg::BUFFER_DEPTH];
    logic                          held_rd_reg;
    logic                          wr_en;
    logic [srr_pkg::SLOT_W-1:0]    wr_addr;
    logic                          wr_data;
    logic [srr_pkg::SLOT_W-1:0]    rd_addr;

    logic [srr_pkg::SEQ_W-1:0]     distance;
    logic [srr_pkg::SEQ_W-1:0]     frame_succ;
    logic [srr_pkg::SEQ_W-1:0]     expected_succ;
    logic                          frame_ready;
    logic                          accept;
    logic                          out_free;
    logic                          drain_more;

    assign distance      = frame.frame_number - expected_reg;
    assign frame_succ    = frame.frame_number + srr_pkg::SEQ_W'(1);
    assign expected_succ = expected_reg + srr_pkg::SEQ_W'(1);
    assign frame_ready   = (state_reg == ST_IDLE);
    assign accept        = frame.valid && frame_ready;
    assign out_free      = !out_valid_reg || result.ready;
    assign drain_more    = held_rd_reg && (cnt_reg < srr_pkg::CNT_W'(srr_pkg::MAX_RESULTS));

    // Next-state and memory access decode
    always_comb
    begin
        state_next     = state_reg;
        expected_next  = expected_reg;
        pend_next      = pend_reg;
        cnt_next       = cnt_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_nak_next   = out_nak_reg;
        out_num_next   = out_num_reg;
        out_last_next  = out_last_reg;
        wr_en          = 1'b0;
        wr_addr        = srr_pkg::slot_of(expected_reg);
        wr_data        = 1'b0;
        rd_addr        = srr_pkg::slot_of(expected_reg);

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the memory to zero, one entry a cycle
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = 1'b0;
                clr_cnt_next = clr_cnt_reg + srr_pkg::SLOT_W'(1);
                if (clr_cnt_reg == srr_pkg::SLOT_W'(srr_pkg::BUFFER_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (distance == '0)
                    begin
                        // In order: clear its slot, advance, fetch the next held bit
                        wr_en         = 1'b1;
                        wr_addr       = srr_pkg::slot_of(frame.frame_number);
                        wr_data       = 1'b0;
                        rd_addr       = srr_pkg::slot_of(frame_succ);
                        pend_next     = frame.frame_number;
                        expected_next = frame_succ;
                        cnt_next      = srr_pkg::CNT_W'(1);
                        state_next    = ST_DRAIN;
                    end
                    else if (!distance[srr_pkg::SEQ_W-1])
                    begin
                        // Ahead: mark it held if it fits the buffer, then NAK
                        if (distance < srr_pkg::SEQ_W'(srr_pkg::BUFFER_DEPTH))
                        begin
                            wr_en   = 1'b1;
                            wr_addr = srr_pkg::slot_of(frame.frame_number);
                            wr_data = 1'b1;
                        end
                        pend_next  = expected_reg;
                        state_next = ST_NAK;
                    end
                end
            end
            ST_DRAIN:
            begin
                // Emit the pending ACK; carry on while the next frame is held
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_nak_next   = 1'b0;
                    out_num_next   = pend_reg;
                    out_last_next  = !drain_more;
                    if (drain_more)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = srr_pkg::slot_of(expected_reg);
                        wr_data       = 1'b0;
                        rd_addr       = srr_pkg::slot_of(expected_succ);
                        pend_next     = expected_reg;
                        expected_next = expected_succ;
                        cnt_next      = cnt_reg + srr_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_NAK:
            begin
                // Request the expected frame again
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_nak_next   = 1'b1;
                    out_num_next   = pend_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            expected_reg  <= srr_pkg::EXPECTED_INIT;
            cnt_reg       <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            expected_reg  <= expected_next;
            cnt_reg       <= cnt_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_nak_reg  <= out_nak_next;
        out_num_reg  <= out_num_next;
        out_last_reg <= out_last_next;
    end

    // Held-frame memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            held_mem[wr_addr] <= wr_data;
        end
        held_rd_reg <= held_mem[rd_addr];
    end

    assign frame.ready       = frame_ready;
    assign result.valid      = out_valid_reg;
    assign result.is_nak     = out_nak_reg;
    assign result.ack_number = out_num_reg;
    assign result.last       = out_last_reg;

endmodule

>>> sv/srr_checker.sv
`timescale 1ns / 1ps

`include "selective_repeat_receiver_unit_defines.svh"

module srr_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      frame_ready,
    input logic                      result_valid,
    input logic                      result_ready,
    input logic                      is_nak,
    input logic [srr_pkg::SEQ_W-1:0] ack_number,
    input logic                      last
);

    // A NAK always closes the words of its frame
    `SRR_ASSERT_NOW(a_nak_is_last, result_valid && is_nak, last, "NAK word without last")

    // No new frame is taken while a drain is still under way
    `SRR_ASSERT_NOW(a_no_take_mid_drain, result_valid && !last, !frame_ready,
        "frame taken while a drain is open")

    // A held word keeps its contents until taken
    `SRR_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(is_nak) && $stable(ack_number) && $stable(last),
        "stalled result word changed")

    // An ACK that is not last is followed by the next frame number
    `SRR_ASSERT_NEXT(a_drain_consecutive,
        result_valid && result_ready && !last && !is_nak,
        !result_valid || (ack_number == $past(ack_number) + srr_pkg::SEQ_W'(1)),
        "drained ACKs not consecutive")

endmodule

bind selective_repeat_receiver_unit srr_checker u_srr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_ready  (frame.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .is_nak       (result.is_nak),
    .ack_number   (result.ack_number),
    .last         (result.last)
);

>>> sim/srr_reply_monitor.sv
`timescale 1ns / 1ps

module srr_reply_monitor (
    input  logic    clk,
    input  logic    rst_n,
    srr_frame_if    frame,
    srr_result_if   result,
    output int      fault_count,
    output int      awaited_count
);

    typedef struct packed {
        logic                      is_nak;
        logic [srr_pkg::SEQ_W-1:0] ack_number;
        logic                      last;
    } reply_word_t;

    localparam logic [srr_pkg::SEQ_W-1:0] HALF_SPACE = {1'b1, {(srr_pkg::SEQ_W-1){1'b0}}};

    reply_word_t                      awaited_replies[$];
    logic [srr_pkg::SEQ_W-1:0]        next_expected;
    logic [srr_pkg::BUFFER_DEPTH-1:0] held_frames;
    int                               faults = 0;

    // Work out the ACK/NAK words one arriving frame gives, and update the window
    function automatic void predict_replies(input logic [srr_pkg::SEQ_W-1:0] fnum);
        reply_word_t               words [srr_pkg::MAX_RESULTS];
        logic [srr_pkg::SEQ_W-1:0] fwd_gap;
        int                        n;
        int                        i;
        fwd_gap = fnum - next_expected;
        n = 0;
        if (fwd_gap == '0)
        begin
            // in order: acknowledge it, then drain consecutive held frames
            words[n] = '{1'b0, fnum, 1'b0};
            n++;
            held_frames[fnum % srr_pkg::BUFFER_DEPTH] = 1'b0;
            next_expected = next_expected + 1'b1;
            while (n < srr_pkg::MAX_RESULTS
                   && held_frames[next_expected % srr_pkg::BUFFER_DEPTH])
            begin
                words[n] = '{1'b0, next_expected, 1'b0};
                n++;
                held_frames[next_expected % srr_pkg::BUFFER_DEPTH] = 1'b0;
                next_expected = next_expected + 1'b1;
            end
        end
        else if (fwd_gap < HALF_SPACE)
        begin
            // early: ask again for the expected one, hold it if it fits the buffer
            words[n] = '{1'b1, next_expected, 1'b0};
            n++;
            if (fwd_gap < srr_pkg::BUFFER_DEPTH)
                held_frames[fnum % srr_pkg::BUFFER_DEPTH] = 1'b1;
        end
        // stale frames give nothing
        for (i = 0; i < n; i++)
        begin
            words[i].last = (i == n - 1);
            awaited_replies.push_back(words[i]);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        reply_word_t want;
        if (!rst_n)
        begin
            next_expected = srr_pkg::EXPECTED_INIT;
            held_frames = '0;
            awaited_replies.delete();
        end
        else
        begin
            // predict on every accepted frame word
            if (frame.valid && frame.ready)
                predict_replies(frame.frame_number);
            // compare each accepted result word with the oldest prediction
            if (result.valid && result.ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $error("result word with nothing awaited: is_nak %0d ack_number %0d last %0d",
                           result.is_nak, result.ack_number, result.last);
                    faults++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (result.is_nak !== want.is_nak)
                    begin
                        $error("is_nak: expected %0d, got %0d", want.is_nak, result.is_nak);
                        faults++;
                    end
                    if (result.ack_number !== want.ack_number)
                    begin
                        $error("ack_number: expected %0d, got %0d",
                               want.ack_number, result.ack_number);
                        faults++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, result.last);
                        faults++;
                    end
                end
            end
        end
        fault_count <= faults;
        awaited_count <= awaited_replies.size();
    end

endmodule

>>> sim/selective_repeat_receiver_unit_test.sv
`timescale 1ns / 1ps

module selective_repeat_receiver_unit_test;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int WINDOW_MAX    = 40;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    int                        fault_count;
    int                        awaited_count;
    logic [srr_pkg::SEQ_W-1:0] window_base;
    int                        sent_count = 0;

    srr_frame_if  frame_ch ();
    srr_result_if result_ch ();

    selective_repeat_receiver_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch)
    );

    srr_reply_monitor reply_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame         (frame_ch),
        .result        (result_ch),
        .fault_count   (fault_count),
        .awaited_count (awaited_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short pauses, now and then none, a few long ones
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Offer one frame word, hold it until taken, then pause if asked
    task automatic offer_frame(input logic [srr_pkg::SEQ_W-1:0] fnum, input int gap);
        frame_ch.valid <= 1'b1;
        frame_ch.frame_number <= fnum;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            frame_ch.frame_number <= srr_pkg::SEQ_W'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Send one window of frames out of order with losses and repeats,
    // then retransmit, lowest first, whatever the receiver could not hold
    task automatic send_window();
        int  order [WINDOW_MAX];
        bit  missing [WINDOW_MAX];
        int  span;
        int  r;
        int  i;
        int  j;
        int  tmp;
        bit  reversed;
        r = $urandom_range(0, 99);
        if (r < 80)
            span = $urandom_range(1, 8);
        else if (r < 95)
            span = $urandom_range(9, srr_pkg::BUFFER_DEPTH - 1);
        else
            span = $urandom_range(srr_pkg::BUFFER_DEPTH, WINDOW_MAX);
        reversed = ($urandom_range(0, 3) == 0);
        for (i = 0; i < span; i++)
        begin
            order[i] = reversed ? span - 1 - i : i;
            missing[i] = 1'b0;
        end
        // mix neighbours a little
        if (!reversed)
        begin
            for (i = 0; i < span - 1; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    j = i + 1 + $urandom_range(0, 2);
                    if (j >= span)
                        j = span - 1;
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
            end
        end
        // stray frames between windows: anywhere, or stale
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            offer_frame(srr_pkg::SEQ_W'($urandom), idle_length());
            sent_count++;
        end
        else if (r < 18)
            offer_frame(window_base - srr_pkg::SEQ_W'($urandom_range(1, 2000)),
                        idle_length());
        // first pass
        for (i = 0; i < span; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                missing[order[i]] = 1'b1;
            else
            begin
                offer_frame(window_base + srr_pkg::SEQ_W'(order[i]), idle_length());
                sent_count++;
                if (order[i] >= srr_pkg::BUFFER_DEPTH)
                    missing[order[i]] = 1'b1;
                if ($urandom_range(0, 9) == 0)
                begin
                    offer_frame(window_base + srr_pkg::SEQ_W'(order[i]), idle_length());
                    sent_count++;
                end
            end
        end
        // retransmit
        for (i = 0; i < span; i++)
        begin
            if (missing[i])
            begin
                offer_frame(window_base + srr_pkg::SEQ_W'(i), idle_length());
                sent_count++;
            end
        end
        window_base = window_base + srr_pkg::SEQ_W'(span);
    endtask

    // Stimulus and verdict
    initial
    begin
        frame_ch.valid <= 1'b0;
        frame_ch.frame_number <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // stale frames: just behind, at the wrap and at the half-space edge
        offer_frame(16'h0000, idle_length());
        offer_frame(16'hFFFF, idle_length());
        offer_frame(16'h8001, idle_length());
        // farthest early frame, too far to hold
        offer_frame(16'h8000, idle_length());
        // first frame past the buffer, then the last one that fits
        offer_frame(16'h0021, idle_length());
        offer_frame(16'h0020, idle_length());
        // early frame twice, then the gap filled: drain of one held frame
        offer_frame(16'h0002, idle_length());
        offer_frame(16'h0002, idle_length());
        offer_frame(16'h0001, idle_length());
        // reverse order: drain of two held frames
        offer_frame(16'h0005, idle_length());
        offer_frame(16'h0004, idle_length());
        offer_frame(16'h0003, idle_length());
        // alternating bit patterns, one far ahead and one behind
        offer_frame(16'h5555, idle_length());
        offer_frame(16'hAAAA, idle_length());
        // frames 1 to 5 are in, frame 32 is still held
        window_base = 16'd6;

        // windows of mixed frames until the item budget is spent
        while (sent_count < 500)
            send_window();

        frame_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0 && awaited_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stalls, and one long hold while frames keep coming
    initial
    begin : result_pacing
        int  burst;
        int  stall;
        int  elapsed;
        bit  long_hold_done;
        elapsed = 0;
        long_hold_done = 1'b0;
        result_ch.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            result_ch.ready <= 1'b1;
            burst = $urandom_range(1, 40);
            repeat (burst) @(posedge clk);
            elapsed += burst;
            if (!long_hold_done && elapsed >= 400)
            begin
                stall = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            else
                stall = idle_length();
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                elapsed += stall;
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no word accepted for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
